### sv/msh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msh_pkg
// shared widths, codes and state type of the multi-series history ring
// ----------------------------------------------------------------------------
package msh_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned SER_W  = 3;
  localparam int unsigned IDX_W  = 7;
  localparam int unsigned CNT_W  = 8;

  // slot content that marks a missing sample
  localparam logic [DATA_W-1:0] HOLE_MARK = 32'h7FFF_FFFF;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

### sv/msh_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msh_in_if
// request channel of the history ring: valid/ready plus one request
// ----------------------------------------------------------------------------
interface msh_in_if import msh_pkg::*; ();

  logic              valid;
  logic              ready;
  logic              op;
  logic [SER_W-1:0]  series;
  logic [DATA_W-1:0] sample;
  logic              known;
  logic [IDX_W-1:0]  point_index;

  modport source (output valid, op, series, sample, known, point_index, input ready);
  modport sink   (input valid, op, series, sample, known, point_index, output ready);

endinterface

### sv/msh_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msh_out_if
// result channel of the history ring: valid/ready plus one result
// ----------------------------------------------------------------------------
interface msh_out_if import msh_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] point_value;
  logic              point_is_hole;
  logic [IDX_W-1:0]  oldest_index;
  logic              range_valid;
  logic [DATA_W-1:0] min_value;
  logic [DATA_W-1:0] max_value;
  logic [CNT_W-1:0]  real_count;

  modport source (output valid, point_value, point_is_hole, oldest_index, range_valid,
                  min_value, max_value, real_count, input ready);
  modport sink   (input valid, point_value, point_is_hole, oldest_index, range_valid,
                  min_value, max_value, real_count, output ready);

endinterface

### sv/multi_series_history_ring_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_series_history_ring_top
// per-series ring buffers of signed samples with min/max/count reporting
// ----------------------------------------------------------------------------
// Holds SERIES ring buffers of POINTS signed 32-bit samples in one synchronous
// single-port-write memory; a missing sample is stored as the hole mark
// 0x7FFFFFFF. After reset the block sweeps the whole memory to holes, one
// entry a cycle (SERIES * 2**clog2(POINTS) entries, 1024 at the defaults), and
// takes no request until the sweep ends. A push writes the sample (or a hole)
// at the series' write position and advances it; a read picks out one slot.
// Every request to a series below SERIES then scans all POINTS slots of its
// series, one memory read a cycle, to form min, max and real-point count; a
// request to a series beyond SERIES skips the write and the scan and yields an
// all-zero result. A push passes through the write, scan, drain and done
// states, a read through scan, drain and done. Requests go one at a time; a
// finished result waits in the output register while the next request runs.
// ----------------------------------------------------------------------------
module multi_series_history_ring_top import msh_pkg::*; #(
  parameter int unsigned SERIES = 8,
  parameter int unsigned POINTS = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  msh_in_if.sink    in_if,
  msh_out_if.source out_if
);

  // derived sizes
  localparam int unsigned SW    = (SERIES > 1) ? $clog2(SERIES) : 1;
  localparam int unsigned PW    = $clog2(POINTS);
  localparam int unsigned AW    = SW + PW;
  localparam int unsigned DEPTH = SERIES * (2 ** PW);
  localparam int unsigned NW    = PW + 1;
  localparam int unsigned CW    = (PW > IDX_W) ? PW : IDX_W;
  localparam int unsigned KW    = (NW > CNT_W) ? NW : CNT_W;

  // control state
  state_t         state_r, state_nxt;
  logic [AW-1:0]  clr_r;
  logic [PW-1:0]  wp_r [SERIES];
  logic [NW-1:0]  scan_r;
  logic           rd_valid_r;
  logic [PW-1:0]  rd_idx_r;

  // latched request
  logic              op_r;
  logic              known_r;
  logic              ser_ok_r;
  logic [SER_W-1:0]  ser_r;
  logic [DATA_W-1:0] sample_r;
  logic [IDX_W-1:0]  idx_r;

  // point store, read data registered
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [DATA_W-1:0] mem_wd;
  logic              mem_re;
  logic [AW-1:0]     mem_ra;

  // scan accumulators
  logic [NW-1:0]     cnt_r;
  logic [DATA_W-1:0] min_r;
  logic [DATA_W-1:0] max_r;
  logic [DATA_W-1:0] pv_r;
  logic              ph_r;

  // output register
  logic              out_valid_r;
  logic [DATA_W-1:0] out_point_value_r;
  logic              out_point_is_hole_r;
  logic [IDX_W-1:0]  out_oldest_index_r;
  logic              out_range_valid_r;
  logic [DATA_W-1:0] out_min_value_r;
  logic [DATA_W-1:0] out_max_value_r;
  logic [CNT_W-1:0]  out_real_count_r;

  logic              in_accept;
  logic              in_ready;
  logic              load_out;
  logic              in_ser_ok;
  logic [SW-1:0]     sel;
  logic [PW-1:0]     wp_cur;
  logic [CW-1:0]     wp_wide;
  logic [KW-1:0]     cnt_wide;
  logic [DATA_W-1:0] push_val;
  logic              rd_is_hole;

  assign in_accept = in_if.valid && in_ready;
  assign in_ser_ok = (32'(in_if.series) < SERIES);
  assign sel       = SW'(ser_r);
  assign wp_cur    = wp_r[sel];
  assign wp_wide   = CW'(wp_cur);
  assign cnt_wide  = KW'(cnt_r);
  assign rd_is_hole = (rd_data_r == HOLE_MARK);

  // a real sample equal to the hole mark is nudged one below it
  always_comb begin
    if (!known_r) begin
      push_val = HOLE_MARK;
    end else if (sample_r == HOLE_MARK) begin
      push_val = HOLE_MARK - 1'b1;
    end else begin
      push_val = sample_r;
    end
  end

  // sequencer: next state and memory port control
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    load_out  = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = clr_r;
    mem_wd    = HOLE_MARK;
    mem_re    = 1'b0;
    mem_ra    = {sel, scan_r[PW-1:0]};
    case (state_r)
      ST_CLEAR: begin
        // reset sweep fills every slot with the hole mark
        mem_we = 1'b1;
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_if.valid) begin
          if (!in_ser_ok) begin
            state_nxt = ST_DONE;
          end else if (in_if.op == OP_PUSH) begin
            state_nxt = ST_WRITE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_WRITE: begin
        // push lands before the scan starts, so the scan sees it
        mem_we    = 1'b1;
        mem_wa    = {sel, wp_cur};
        mem_wd    = push_val;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        mem_re = 1'b1;
        if (scan_r == NW'(POINTS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read data is folded in this cycle
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_r      <= '0;
      scan_r     <= '0;
      rd_valid_r <= 1'b0;
      for (int s = 0; s < SERIES; s++) begin
        wp_r[s] <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      rd_valid_r <= mem_re;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (state_r == ST_WRITE) begin
        wp_r[sel] <= (wp_cur == PW'(POINTS - 1)) ? '0 : wp_cur + 1'b1;
      end
      if (state_r == ST_SCAN) begin
        scan_r <= scan_r + 1'b1;
      end else begin
        scan_r <= '0;
      end
    end
  end

  // point store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  // request latch, scan accumulation and read capture
  always_ff @(posedge clk) begin
    rd_idx_r <= scan_r[PW-1:0];
    if (in_accept) begin
      op_r     <= in_if.op;
      ser_r    <= in_if.series;
      sample_r <= in_if.sample;
      known_r  <= in_if.known;
      idx_r    <= in_if.point_index;
      ser_ok_r <= in_ser_ok;
      cnt_r    <= '0;
      min_r    <= '0;
      max_r    <= '0;
      pv_r     <= '0;
      ph_r     <= 1'b0;
    end else if (rd_valid_r) begin
      if (!rd_is_hole) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == '0 || $signed(rd_data_r) < $signed(min_r)) begin
          min_r <= rd_data_r;
        end
        if (cnt_r == '0 || $signed(max_r) < $signed(rd_data_r)) begin
          max_r <= rd_data_r;
        end
      end
      // a read index past the ring never matches a slot number
      if (op_r == OP_READ && CW'(idx_r) == CW'(rd_idx_r)) begin
        pv_r <= rd_data_r;
        ph_r <= rd_is_hole;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (ser_ok_r) begin
        out_point_value_r   <= pv_r;
        out_point_is_hole_r <= ph_r;
        out_oldest_index_r  <= wp_wide[IDX_W-1:0];
        out_range_valid_r   <= (cnt_r != '0);
        out_min_value_r     <= min_r;
        out_max_value_r     <= max_r;
        out_real_count_r    <= cnt_wide[CNT_W-1:0];
      end else begin
        // series beyond the ring set: everything zero
        out_point_value_r   <= '0;
        out_point_is_hole_r <= 1'b0;
        out_oldest_index_r  <= '0;
        out_range_valid_r   <= 1'b0;
        out_min_value_r     <= '0;
        out_max_value_r     <= '0;
        out_real_count_r    <= '0;
      end
    end
  end

  assign in_if.ready          = in_ready;
  assign out_if.valid         = out_valid_r;
  assign out_if.point_value   = out_point_value_r;
  assign out_if.point_is_hole = out_point_is_hole_r;
  assign out_if.oldest_index  = out_oldest_index_r;
  assign out_if.range_valid   = out_range_valid_r;
  assign out_if.min_value     = out_min_value_r;
  assign out_if.max_value     = out_max_value_r;
  assign out_if.real_count    = out_real_count_r;

  // checks

  // a series never counts more real points than it has slots
  // (the count is only set up once a request has been taken)
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLEAR && state_r != ST_IDLE) |-> (cnt_r <= NW'(POINTS)))
    else $error("real-point count beyond ring length");

  // an empty series reports zero min and max
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_range_valid_r) |-> (out_min_value_r == '0 && out_max_value_r == '0))
    else $error("empty series with nonzero range");

  // the store is not written while a scan reads it
  a_no_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_DRAIN) |-> !mem_we)
    else $error("store written during scan");

  // the write position stays inside the ring
  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |-> (NW'(wp_cur) < NW'(POINTS)))
    else $error("write position outside ring");

endmodule
